// ----- design/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/ffa_pkg.sv -----
// Types and constants of the first-fit extent allocator.
// No dependencies; used by the interfaces, the cell and the top level.
package ffa_pkg;

   localparam int ID_W     = 20;
   localparam int FIRST_W  = 19;
   localparam int STATUS_W = 2;

   localparam logic [FIRST_W-1:0] POOL_FIRST_ID_RESET = 19'd29294;
   localparam logic [ID_W-1:0]    POOL_SIZE_RESET     = 20'd262144;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   localparam logic CSR_POOL_FIRST_ID = 1'b0;
   localparam logic CSR_POOL_SIZE     = 1'b1;

   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] base;
      logic [ID_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic rotate;
      logic drop;
      logic append;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic            operation;
      logic [ID_W-1:0] run_base;
      logic [ID_W-1:0] run_length;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     granted_base;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ----- design/ffa_chan_if.sv -----
// Valid/ready channels for allocator requests and responses.
// Depends on ffa_pkg for the payload types.
interface ffa_req_if;
   import ffa_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ffa_rsp_if;
   import ffa_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/ffa_cell.sv -----
// One slot of the extent chain: holds an extent and takes its neighbor's on rotate.
// Depends on ffa_pkg.
module ffa_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ffa_pkg::cell_ctrl_type ctrl,
   input  ffa_pkg::entry_type     init_ent,
   input  ffa_pkg::entry_type     nxt_ent,
   input  logic                   prv_valid,
   input  ffa_pkg::entry_type     head_ent,
   input  ffa_pkg::entry_type     app_ent,
   output ffa_pkg::entry_type     ent
);
   import ffa_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      priority if (ctrl.clear) begin
         ent_in = init_ent;
      end else if (ctrl.rotate) begin
         // tail slot of the ring takes the head back, or a hole on drop
         if (nxt_ent.valid) begin
            ent_in = nxt_ent;
         end else if (ent_ff.valid) begin
            ent_in = ctrl.drop ? '0 : head_ent;
         end
      end else if (ctrl.append) begin
         if (!ent_ff.valid && prv_valid) begin
            ent_in = app_ent;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.base <= ent_in.base;
      ent_ff.len  <= ent_in.len;
   end

   assign ent = ent_ff;

endmodule

// ----- design/first_fit_extent_allocator_core.sv -----
// First-fit extent allocator: a chain of cells holding the free extents in table order.
// Depends on ffa_pkg, ffa_chan_if, ffa_cell and assert_macros.svh.
//
// Requests are handled one at a time. An allocate rotates the whole chain of
// extents once through the head cell, one extent per cycle, removing the
// first fitting extent as it passes. After reset and after each configuration
// write the table is rebuilt, and no request is taken while it is. A new
// request may be taken while a response is still waiting on rsp_chan.
module first_fit_extent_allocator_core #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   ffa_req_if.sink                       req_chan,
   ffa_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [ffa_pkg::ID_W-1:0]      csr_wdata
);
   import ffa_pkg::*;

   `include "assert_macros.svh"

   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

   state_type            state_ff, state_in;
   logic [FIRST_W-1:0]   first_ff;
   logic [ID_W-1:0]      size_ff;
   logic                 rebuild_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        step_ff, step_in;
   logic                 found_ff, found_in;
   logic [ID_W-1:0]      eb_ff, eb_in;
   logic [ID_W-1:0]      el_ff, el_in;
   logic [ID_W-1:0]      len_ff, len_in;
   logic [ID_W-1:0]      res_base_ff, res_base_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_pay_ff, rsp_pay_in;

   cell_ctrl_type        ctrl;
   entry_type            app_ent;
   entry_type            init0;
   entry_type            ents [MAX_EXTENTS];
   logic [MAX_EXTENTS-1:0] valid_vec;
   logic                 accept;
   logic                 found_now;
   logic                 cnt_ok;
   logic                 step_ok;
   logic                 free_accept;

   // ---------------------------------------------------------------- cells
   assign init0 = '{valid: (size_ff != '0), base: {1'b0, first_ff}, len: size_ff};

   for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
      entry_type nxt;
      logic      prv;
      entry_type init;

      if (k == MAX_EXTENTS - 1) begin : g_last
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = ents[k+1];
      end

      if (k == 0) begin : g_head
         assign prv  = 1'b1;
         assign init = init0;
      end else begin : g_body
         assign prv  = ents[k-1].valid;
         assign init = '0;
      end

      ffa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .init_ent  (init),
         .nxt_ent   (nxt),
         .prv_valid (prv),
         .head_ent  (ents[0]),
         .app_ent   (app_ent),
         .ent       (ents[k])
      );

      assign valid_vec[k] = ents[k].valid;
   end

   // ---------------------------------------------------------------- control
   assign req_chan.ready = (state_ff == ST_IDLE) && !rebuild_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign found_now      = (state_ff == ST_SCAN) && (step_ff != '0) && ents[0].valid &&
                           !found_ff && (ents[0].len >= len_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      eb_in         = eb_ff;
      el_in         = el_ff;
      len_in        = len_ff;
      res_base_in   = res_base_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pay_in    = rsp_pay_ff;
      ctrl          = '0;
      app_ent       = '0;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (rebuild_ff) begin
         ctrl.clear = 1'b1;
         cnt_in     = (size_ff != '0) ? CW'(1) : '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_base_in = '0;
               state_in    = ST_DONE;
               if (req_chan.payload.operation == OP_ALLOC) begin
                  len_in = req_chan.payload.run_length;
                  if (req_chan.payload.run_length == '0) begin
                     res_status_in = STATUS_BAD;
                  end else begin
                     step_in  = cnt_ff;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               end else begin
                  priority if (req_chan.payload.run_base == '0) begin
                     res_status_in = STATUS_OK;
                  end else if (req_chan.payload.run_base < {1'b0, first_ff} ||
                               req_chan.payload.run_length == '0) begin
                     res_status_in = STATUS_BAD;
                  end else if (cnt_ff == CNT_MAX) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     res_status_in = STATUS_OK;
                     ctrl.append   = 1'b1;
                     app_ent       = '{valid: 1'b1,
                                       base:  req_chan.payload.run_base,
                                       len:   req_chan.payload.run_length};
                     cnt_in        = cnt_ff + CW'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (step_ff != '0) begin
               // rotate one extent through the head; drop the first fit
               ctrl.rotate = 1'b1;
               step_in     = step_ff - CW'(1);
               if (found_now) begin
                  ctrl.drop = 1'b1;
                  found_in  = 1'b1;
                  eb_in     = ents[0].base;
                  el_in     = ents[0].len;
               end
            end else begin
               state_in = ST_DONE;
               if (found_ff) begin
                  res_base_in   = eb_ff;
                  res_status_in = STATUS_OK;
                  if (el_ff > len_ff) begin
                     ctrl.append = 1'b1;
                     app_ent     = '{valid: 1'b1, base: eb_ff + len_ff, len: el_ff - len_ff};
                  end else begin
                     cnt_in = cnt_ff - CW'(1);
                  end
               end else begin
                  res_base_in   = '0;
                  res_status_in = STATUS_NO_FIT;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pay_in   = '{granted_base: res_base_ff, status: res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= POOL_FIRST_ID_RESET;
         size_ff      <= POOL_SIZE_RESET;
         rebuild_ff   <= 1'b1;
         cnt_ff       <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rebuild_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index[0])
               CSR_POOL_FIRST_ID: first_ff <= csr_wdata[FIRST_W-1:0];
               CSR_POOL_SIZE:     size_ff  <= csr_wdata;
               default:           size_ff  <= size_ff;
            endcase
         end
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eb_ff         <= eb_in;
      el_ff         <= el_in;
      len_ff        <= len_in;
      res_base_ff   <= res_base_in;
      res_status_ff <= res_status_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_pay_ff;

   // ---------------------------------------------------------------- checks
   assign cnt_ok      = (state_ff != ST_IDLE) || rebuild_ff ||
                        ($countones(valid_vec) == int'(cnt_ff));
   assign step_ok     = (state_ff != ST_SCAN) || (step_ff <= cnt_ff);
   assign free_accept = accept && (req_chan.payload.operation == OP_FREE);

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_MAX, "extent count past table size")

   `ASSERT_ALWAYS(a_cnt_match, clock, reset, cnt_ok, "valid cells disagree with extent count")

   `ASSERT_ALWAYS(a_step_bound, clock, reset, step_ok, "scan step past extent count")

   `ASSERT_NEXT(a_free_done, clock, reset, free_accept, state_ff == ST_DONE, "free request late")

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for first_fit_extent_allocator_core: drives requests and CSR writes,
// predicts each response from a shadow copy of the extent table and compares them in order.
// Depends on ffa_pkg and the ffa_req_if / ffa_rsp_if interfaces.
module testbench;
   import ffa_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RUN_MAX      = 524288;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
   localparam int PRINT_LIMIT  = 200;

   typedef enum {MIX_EVEN, MIX_ALLOC, MIX_FREE} mix_type;

   class extent_scoreboard_type #(int DEPTH = 64);
      bit [ID_W-1:0]    ext_base [DEPTH];
      bit [ID_W-1:0]    ext_len [DEPTH];
      int unsigned      ext_count;
      bit [FIRST_W-1:0] first_id;
      bit [ID_W-1:0]    pool_len;
      rsp_type          expected_q[$];
      bit [ID_W-1:0]    live_base[$];
      bit [ID_W-1:0]    live_len[$];
      int unsigned      fail_count;

      function new();
         first_id = POOL_FIRST_ID_RESET;
         pool_len = POOL_SIZE_RESET;
         fail_count = 0;
         rebuild();
      endfunction

      function void rebuild();
         ext_count = 0;
         if (pool_len != 0) begin
            ext_base[0] = {1'b0, first_id};
            ext_len[0] = pool_len;
            ext_count = 1;
         end
         live_base.delete();
         live_len.delete();
      endfunction

      function void write_register(logic [0:0] index, bit [ID_W-1:0] data);
         if (index == CSR_POOL_FIRST_ID) begin
            first_id = data[FIRST_W-1:0];
         end else begin
            pool_len = data;
         end
         rebuild();
      endfunction

      task report(string what);
         if (fail_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
         fail_count++;
      endtask

      function void note_request(req_type r);
         rsp_type       e;
         int            hit;
         bit [ID_W-1:0] eb;
         bit [ID_W-1:0] el;
         e.granted_base = '0;
         e.status = STATUS_OK;
         if (r.operation == OP_ALLOC) begin
            if (r.run_length == 0) begin
               e.status = STATUS_BAD;
            end else begin
               hit = -1;
               for (int i = 0; i < ext_count; i++) begin
                  if (ext_len[i] >= r.run_length) begin
                     hit = i;
                     break;
                  end
               end
               if (hit < 0) begin
                  e.status = STATUS_NO_FIT;
               end else begin
                  eb = ext_base[hit];
                  el = ext_len[hit];
                  // compact the table behind the chosen extent
                  for (int j = hit; j + 1 < ext_count; j++) begin
                     ext_base[j] = ext_base[j + 1];
                     ext_len[j] = ext_len[j + 1];
                  end
                  ext_count--;
                  if (el > r.run_length) begin
                     ext_base[ext_count] = eb + r.run_length;
                     ext_len[ext_count] = el - r.run_length;
                     ext_count++;
                  end
                  e.granted_base = eb;
                  live_base = {live_base, eb};
                  live_len = {live_len, r.run_length};
                  if (live_base.size() > 512) begin
                     void'(live_base.pop_front());
                     void'(live_len.pop_front());
                  end
               end
            end
         end else if (r.run_base != 0) begin
            if (r.run_base < first_id || r.run_length == 0) begin
               e.status = STATUS_BAD;
            end else if (ext_count >= DEPTH) begin
               e.status = STATUS_FULL;
            end else begin
               ext_base[ext_count] = r.run_base;
               ext_len[ext_count] = r.run_length;
               ext_count++;
            end
         end
         expected_q = {expected_q, e};
      endfunction

      task check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("response with no request outstanding: base %0d status %0d",
                             got.granted_base, got.status));
         end else begin
            e = expected_q.pop_front();
            if (got.granted_base !== e.granted_base) begin
               report($sformatf("granted_base got %0d, expected %0d",
                                got.granted_base, e.granted_base));
            end
            if (got.status !== e.status) begin
               report($sformatf("status got %0d, expected %0d", got.status, e.status));
            end
         end
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            csr_we;
   logic [0:0]      csr_index;
   logic [ID_W-1:0] csr_wdata;
   bit              quiet_sender;
   bit              quiet_receiver;
   int unsigned     idle_cycles = 0;
   int unsigned     rsp_hold = 0;

   ffa_req_if req_chan();
   ffa_rsp_if rsp_chan();

   extent_scoreboard_type #(TABLE_DEPTH) sb;

   first_fit_extent_allocator_core #(.MAX_EXTENTS(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [ID_W-1:0] pick_length(int unsigned most);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (most < 2) return 20'd1;
      if (roll < 70) return ID_W'($urandom_range(1, (most < 64) ? most : 64));
      if (roll < 90) return ID_W'($urandom_range(1, (most < 4096) ? most : 4096));
      return ID_W'($urandom_range(1, most));
   endfunction

   function automatic req_type make_request(mix_type mix);
      req_type     r;
      int unsigned roll;
      int unsigned slot;
      int unsigned span;
      int unsigned floor_id;
      int unsigned alloc_pct;
      r.operation = OP_ALLOC;
      r.run_base = ID_W'($urandom_range(0, 20'hFFFFF));
      r.run_length = pick_length(RUN_MAX);
      alloc_pct = (mix == MIX_ALLOC) ? 75 : (mix == MIX_FREE) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         // malformed or odd requests
         r.operation = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: begin
               r.run_length = '0;
            end
            1: begin
               r.run_length = ID_W'(RUN_MAX);
            end
            2: begin
               r.run_base = '0;
            end
            default: begin
               if (sb.first_id != 0) begin
                  r.run_base = ID_W'($urandom_range(0, sb.first_id - 1));
               end
            end
         endcase
      end else if ($urandom_range(0, 99) < alloc_pct) begin
         if (sb.ext_count != 0 && $urandom_range(0, 9) < 8) begin
            slot = $urandom_range(0, sb.ext_count - 1);
            span = (sb.ext_len[slot] < RUN_MAX) ? sb.ext_len[slot] : RUN_MAX;
            r.run_length = ($urandom_range(0, 7) == 0) ? ID_W'(span) : pick_length(span);
         end
      end else begin
         r.operation = OP_FREE;
         if (sb.live_base.size() != 0 && $urandom_range(0, 3) != 0) begin
            // hand back a run granted earlier
            slot = $urandom_range(0, sb.live_base.size() - 1);
            r.run_base = sb.live_base[slot];
            r.run_length = sb.live_len[slot];
            sb.live_base.delete(slot);
            sb.live_len.delete(slot);
         end else begin
            floor_id = (sb.first_id == 0) ? 1 : sb.first_id;
            r.run_base = ID_W'($urandom_range(floor_id, 20'hFFFFF));
         end
      end
      return r;
   endfunction

   // hold valid until the request is taken; valid stays high for a back-to-back request
   task automatic send_request(logic op, bit [ID_W-1:0] base, bit [ID_W-1:0] len);
      req_type     r;
      int unsigned gap;
      r.operation = op;
      r.run_base = base;
      r.run_length = len;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] index, bit [ID_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic run_phase(bit [FIRST_W-1:0] first, bit [ID_W-1:0] size, mix_type mix,
                            int unsigned count, bit calm_tx, bit calm_rx);
      req_type r;
      drain_responses();
      // bit 19 of the first-id write is don't-care; toggle it anyway
      write_register(CSR_POOL_FIRST_ID, {1'($urandom_range(0, 1)), first});
      write_register(CSR_POOL_SIZE, size);
      csr_we <= 1'b0;
      quiet_sender = calm_tx;
      quiet_receiver = calm_rx;
      repeat (count) begin
         r = make_request(mix);
         send_request(r.operation, r.run_base, r.run_length);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_chan.ready <= 1'b0;
      end else if (quiet_receiver) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_hold = pick_gap();
         rsp_chan.ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_response(rsp_chan.payload);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      sb = new();
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset pool: zero-length allocate, misses, an exact fit, free rejections for a low base and a zero length
      send_request(OP_ALLOC, 20'd0, 20'd0);
      send_request(OP_ALLOC, 20'hFFFFF, 20'd1);
      send_request(OP_ALLOC, 20'd0, ID_W'(RUN_MAX));
      send_request(OP_ALLOC, 20'd0, 20'd262143);
      send_request(OP_ALLOC, 20'd0, 20'd1);
      send_request(OP_FREE, 20'd0, 20'd5);
      send_request(OP_FREE, 20'd0, 20'd0);
      send_request(OP_FREE, 20'd29293, 20'd10);
      send_request(OP_FREE, 20'd1, 20'd1);
      send_request(OP_FREE, 20'hFFFFF, 20'd0);
      send_request(OP_FREE, 20'hFFFFF, ID_W'(RUN_MAX));
      send_request(OP_FREE, 20'd29294, 20'd1);
      // remainder base wraps past the top of the id space
      send_request(OP_ALLOC, 20'd0, 20'd2);
      send_request(OP_ALLOC, 20'd0, 20'd1);
      send_request(OP_ALLOC, 20'd0, 20'd524286);
      send_request(OP_FREE, 20'd29294, 20'd1);
      send_request(OP_FREE, 20'd30000, 20'd100);
      send_request(OP_FREE, 20'd40000, 20'd50);
      send_request(OP_ALLOC, 20'h55555, 20'd60);
      send_request(OP_ALLOC, 20'hAAAAA, 20'd45);
      send_request(OP_ALLOC, 20'd0, 20'd41);

      run_phase(19'd0, 20'd1, MIX_EVEN, 135, 1'b0, 1'b0);
      run_phase(19'd524287, 20'hFFFFF, MIX_EVEN, 135, 1'b1, 1'b1);
      run_phase(19'd1000, 20'd0, MIX_FREE, 135, 1'b0, 1'b0);
      run_phase(POOL_FIRST_ID_RESET, POOL_SIZE_RESET, MIX_FREE, 135, 1'b0, 1'b0);
      run_phase(19'd12345, 20'd524288, MIX_ALLOC, 135, 1'b1, 1'b0);
      run_phase(FIRST_W'($urandom_range(0, 524287)), ID_W'($urandom_range(1, 4096)),
                MIX_EVEN, 135, 1'b0, 1'b0);
      run_phase(FIRST_W'($urandom_range(0, 524287)), ID_W'($urandom_range(1, 20'hFFFFF)),
                MIX_FREE, 135, 1'b0, 1'b1);
      run_phase(19'd300000, 20'd64, MIX_ALLOC, 135, 1'b0, 1'b0);

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
